// File: src/sdda_pkg.sv
// Shared types, codes and style pattern logic for the styled DDA line rasterizer.
package sdda_pkg;

    // Operation codes carried by an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Line style codes.
    localparam logic [1:0] STYLE_DOT      = 2'd0;
    localparam logic [1:0] STYLE_DASH     = 2'd1;
    localparam logic [1:0] STYLE_DASH_DOT = 2'd2;
    localparam logic [1:0] STYLE_SOLID    = 2'd3;

    localparam int PHASE_BITS = 5;
    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [1:0]            style_t;

    localparam phase_t DOT_PERIOD   = phase_t'(6);
    localparam phase_t DASH_PERIOD  = phase_t'(20);
    localparam phase_t DASH_ON_LAST = phase_t'(10);
    localparam int     DOT_EVERY    = 5;
    // Dash-dot marks at multiples of five that fall outside the dash.
    localparam phase_t DOT_LATE_MARK = phase_t'(3 * DOT_EVERY);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // start item accepted
        logic step;      // step item accepted, output register loads
        logic div_step;  // one quotient bit per axis
        logic div_last;  // final quotient bit, increments are written
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // the line offered on the input has no steps
    } status_t;

    function automatic logic pattern_draws(input style_t style, input phase_t phase);
        logic draws;
        begin
            draws = 1'b1;
            case (style)
                STYLE_DOT:      draws = (phase == '0);
                STYLE_DASH:     draws = (phase <= DASH_ON_LAST);
                STYLE_DASH_DOT: draws = (phase <= DASH_ON_LAST) || (phase == DOT_LATE_MARK);
                default:        draws = 1'b1;
            endcase
            return draws;
        end
    endfunction

    function automatic phase_t phase_advance(input style_t style, input phase_t phase);
        phase_t period;
        phase_t bumped;
        begin
            period = (style == STYLE_DOT) ? DOT_PERIOD : DASH_PERIOD;
            bumped = phase + phase_t'(1);
            return (bumped >= period) ? '0 : bumped;
        end
    endfunction

endpackage

// File: src/styled_dda_line_rasterizer.sv
// Top level of the styled DDA line rasterizer: controller plus datapath.
//
//   channel  direction  handshake           payload
//   input    in         in_valid/in_stall   operation, x_start, y_start, x_end, y_end, style
//   output   out        out_valid/out_stall pixel_x, pixel_y, plot, last, idle
//
// A step item does one position add per axis, and results leave through
// a single output register that can be refilled in the cycle it is drained.
// A start item of a line with nonzero length holds the input while the
// restoring divider forms one increment bit per axis per cycle.
// Reset clears the line state, so a step right after reset returns idle.
// A stalled output holds its item and stalls the input until it is taken.
module styled_dda_line_rasterizer #(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [1:0]            style,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  plot,
    output logic                  last,
    output logic                  idle
);

    sdda_pkg::cmd_t    cmd;
    sdda_pkg::status_t status;

    sdda_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .operation(operation),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sdda_datapath #(
        .COORD_BITS   (COORD_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .x_start(x_start),
        .y_start(y_start),
        .x_end  (x_end),
        .y_end  (y_end),
        .style  (style),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .plot   (plot),
        .last   (last),
        .idle   (idle)
    );

endmodule

// File: src/sdda_ctrl.sv
// Controller: handshakes, increment division sequencing and output valid.
module sdda_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    output logic              out_valid,
    input  logic              out_stall,
    input  sdda_pkg::status_t status,
    output sdda_pkg::cmd_t    cmd
);

    localparam int CNT_BITS = $clog2(FRACTION_BITS);

    localparam logic ST_READY  = 1'b0;
    localparam logic ST_DIVIDE = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic out_free;
    logic accept;
    logic start_acc;
    logic step_acc;
    logic div_last;

    // The output register may be refilled in the same cycle it is drained.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_READY) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign start_acc = accept && (operation == sdda_pkg::OP_START);
    assign step_acc  = accept && (operation == sdda_pkg::OP_STEP);
    assign div_last  = (state_reg == ST_DIVIDE) && (cnt_reg == CNT_BITS'(FRACTION_BITS - 1));

    assign cmd.load     = start_acc;
    assign cmd.step     = step_acc;
    assign cmd.div_step = (state_reg == ST_DIVIDE);
    assign cmd.div_last = div_last;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_READY:
            begin
                cnt_next = '0;
                if (start_acc && !status.count_zero)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (div_last)
                begin
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_divide_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> in_stall)
        else $error("input taken while the increment division runs");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step_acc |=> out_valid_reg)
        else $error("accepted step item left no result");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        div_last |=> (state_reg == ST_READY))
        else $error("division did not finish after its last bit");

    a_empty_line_no_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (start_acc && status.count_zero) |=> (state_reg == ST_READY))
        else $error("zero-length line started a division");

endmodule

// File: src/sdda_datapath.sv
// Datapath: span set-up, increment dividers, position accumulators and result register.
module sdda_datapath #(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdda_pkg::cmd_t        cmd,
    output sdda_pkg::status_t     status,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [1:0]            style,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  plot,
    output logic                  last,
    output logic                  idle
);

    localparam int C = COORD_BITS;
    localparam int F = FRACTION_BITS;
    localparam int P = C + F + 2;   // position width
    localparam int I = F + 2;       // increment width, signed

    // Line state.
    logic [P-1:0]         pos_x_reg;
    logic [P-1:0]         pos_y_reg;
    logic [I-1:0]         inc_x_reg;
    logic [I-1:0]         inc_y_reg;
    logic [C:0]           steps_reg;
    sdda_pkg::phase_t     phase_reg;
    sdda_pkg::style_t     style_reg;

    // Division state.
    logic [C-1:0]         div_count_reg;
    logic [C-1:0]         rem_x_reg;
    logic [C-1:0]         rem_y_reg;
    logic [F:0]           quo_x_reg;
    logic [F:0]           quo_y_reg;
    logic                 neg_x_reg;
    logic                 neg_y_reg;

    // Result register.
    logic [C-1:0]         pixel_x_reg;
    logic [C-1:0]         pixel_y_reg;
    logic                 plot_reg;
    logic                 last_reg;
    logic                 idle_reg;

    logic [C:0]           span_x;
    logic [C:0]           span_y;
    logic [C:0]           abs_x;
    logic [C:0]           abs_y;
    logic [C-1:0]         mag_x;
    logic [C-1:0]         mag_y;
    logic [C-1:0]         count;
    logic [C:0]           trial_x;
    logic [C:0]           trial_y;
    logic                 ge_x;
    logic                 ge_y;
    logic [C:0]           diff_x;
    logic [C:0]           diff_y;
    logic [F:0]           quo_x_next;
    logic [F:0]           quo_y_next;
    logic                 active;

    assign span_x = {1'b0, x_end} - {1'b0, x_start};
    assign span_y = {1'b0, y_end} - {1'b0, y_start};
    assign abs_x  = span_x[C] ? ((C+1)'(0) - span_x) : span_x;
    assign abs_y  = span_y[C] ? ((C+1)'(0) - span_y) : span_y;
    assign mag_x  = abs_x[C-1:0];
    assign mag_y  = abs_y[C-1:0];
    assign count  = (mag_x > mag_y) ? mag_x : mag_y;

    assign status.count_zero = (count == '0);

    // Restoring division of the span by the step count, one fraction bit a cycle.
    assign trial_x    = {rem_x_reg, 1'b0};
    assign trial_y    = {rem_y_reg, 1'b0};
    assign ge_x       = (trial_x >= {1'b0, div_count_reg});
    assign ge_y       = (trial_y >= {1'b0, div_count_reg});
    assign diff_x     = trial_x - {1'b0, div_count_reg};
    assign diff_y     = trial_y - {1'b0, div_count_reg};
    assign quo_x_next = {quo_x_reg[F-1:0], ge_x};
    assign quo_y_next = {quo_y_reg[F-1:0], ge_y};

    assign active = (steps_reg != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_count_reg <= count;
            neg_x_reg     <= span_x[C];
            neg_y_reg     <= span_y[C];
            // The span never exceeds the count, so the integer bit is one only for equality.
            quo_x_reg     <= {{F{1'b0}}, (mag_x == count)};
            quo_y_reg     <= {{F{1'b0}}, (mag_y == count)};
            rem_x_reg     <= (mag_x == count) ? '0 : mag_x;
            rem_y_reg     <= (mag_y == count) ? '0 : mag_y;
        end
        else if (cmd.div_step)
        begin
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
            rem_x_reg <= ge_x ? diff_x[C-1:0] : trial_x[C-1:0];
            rem_y_reg <= ge_y ? diff_y[C-1:0] : trial_y[C-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            if (active)
            begin
                pixel_x_reg <= pos_x_reg[F+C-1:F];
                pixel_y_reg <= pos_y_reg[F+C-1:F];
                plot_reg    <= sdda_pkg::pattern_draws(style_reg, phase_reg);
                last_reg    <= (steps_reg == (C+1)'(1));
                idle_reg    <= 1'b0;
            end
            else
            begin
                pixel_x_reg <= '0;
                pixel_y_reg <= '0;
                plot_reg    <= 1'b0;
                last_reg    <= 1'b0;
                idle_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            inc_x_reg <= '0;
            inc_y_reg <= '0;
            steps_reg <= '0;
            phase_reg <= '0;
            style_reg <= '0;
        end
        else if (cmd.load)
        begin
            // Start position is the start pixel plus one half.
            pos_x_reg <= {2'b00, x_start, 1'b1, {(F-1){1'b0}}};
            pos_y_reg <= {2'b00, y_start, 1'b1, {(F-1){1'b0}}};
            inc_x_reg <= '0;
            inc_y_reg <= '0;
            steps_reg <= {1'b0, count};
            phase_reg <= '0;
            style_reg <= style;
        end
        else if (cmd.div_last)
        begin
            inc_x_reg <= neg_x_reg ? (I'(0) - {1'b0, quo_x_next}) : {1'b0, quo_x_next};
            inc_y_reg <= neg_y_reg ? (I'(0) - {1'b0, quo_y_next}) : {1'b0, quo_y_next};
        end
        else if (cmd.step && active)
        begin
            pos_x_reg <= pos_x_reg + {{(P-I){inc_x_reg[I-1]}}, inc_x_reg};
            pos_y_reg <= pos_y_reg + {{(P-I){inc_y_reg[I-1]}}, inc_y_reg};
            steps_reg <= steps_reg - (C+1)'(1);
            phase_reg <= sdda_pkg::phase_advance(style_reg, phase_reg);
        end
    end

    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign plot    = plot_reg;
    assign last    = last_reg;
    assign idle    = idle_reg;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the styled DDA line rasterizer.
module tb_top;

    localparam int COORD = 12;
    localparam int FRAC = 16;
    localparam logic [COORD-1:0] COORD_MAX = '1;
    localparam int NEAR_SPAN = 40;
    localparam int DOT_CYCLE = 6;
    localparam int DASH_CYCLE = 20;
    localparam int DASH_LEN = 10;
    localparam int DOT_SPACING = 5;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SETTLE_CYCLES = 3 * FRAC;
    localparam int MAX_CYCLES = 600000;
    localparam int PRINT_LIMIT = 40;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic             op;
        logic [COORD-1:0] xs;
        logic [COORD-1:0] ys;
        logic [COORD-1:0] xe;
        logic [COORD-1:0] ye;
        logic [1:0]       st;
    } line_item_t;

    typedef struct packed {
        logic [COORD-1:0] px;
        logic [COORD-1:0] py;
        logic             plot;
        logic             last;
        logic             idle;
    } pixel_result_t;

    typedef struct packed {
        line_item_t    item;
        logic          pinned;
        pixel_result_t res;
    } script_row_t;

    localparam int ITEM_BITS = $bits(line_item_t);
    localparam pixel_result_t NO_PIXEL = '0;
    localparam pixel_result_t IDLE_PIXEL = '{12'd0, 12'd0, 1'b0, 1'b0, 1'b1};
    localparam line_item_t STEP_ITEM = '{sdda_pkg::OP_STEP, 12'd0, 12'd0, 12'd0, 12'd0,
                                         sdda_pkg::STYLE_DOT};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic [COORD-1:0] x_start = '0;
    logic [COORD-1:0] y_start = '0;
    logic [COORD-1:0] x_end = '0;
    logic [COORD-1:0] y_end = '0;
    logic [1:0] style = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [COORD-1:0] pixel_x;
    logic [COORD-1:0] pixel_y;
    logic plot;
    logic last;
    logic idle;

    // Typed expectations travel alongside the item they belong to.
    logic pin_valid = 1'b0;
    pixel_result_t pin_result = '0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int lines_started = 0;
    int pixels_checked = 0;
    int idle_seen = 0;
    int last_seen = 0;
    int plotted = 0;

    // Predicted rasterizer state.
    logic [FRAC+COORD+1:0] pos_x = '0;
    logic [FRAC+COORD+1:0] pos_y = '0;
    logic [FRAC+COORD+1:0] inc_x = '0;
    logic [FRAC+COORD+1:0] inc_y = '0;
    int steps_to_go = 0;
    int draw_phase = 0;
    logic [1:0] line_style_q = '0;

    pixel_result_t expected_pixels[$];
    script_row_t directed_rows [DIRECTED_ROWS];

    pixel_result_t seen_pixel;
    pixel_result_t want_pixel;
    logic has_pixel;

    styled_dda_line_rasterizer #(
        .COORD_BITS(COORD),
        .FRACTION_BITS(FRAC)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .x_start(x_start),
        .y_start(y_start),
        .x_end(x_end),
        .y_end(y_end),
        .style(style),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .plot(plot),
        .last(last),
        .idle(idle)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("%0t: pixel %0d %s: got %0d, expected %0d",
                     $realtime, pixels_checked, what, got, want);
        end
    endtask

    // Signed span over step count as a fixed-point increment, wrapped to position width.
    function automatic logic [FRAC+COORD+1:0] slope_of(input int span, input int count);
        longint mag;
        longint q;
        mag = longint'((span < 0) ? -span : span);
        q = (mag << FRAC) / longint'(count);
        if (span < 0)
        begin
            q = -q;
        end
        return q[FRAC+COORD+1:0];
    endfunction

    task automatic rasterize_item(input line_item_t it, output logic produced,
                                  output pixel_result_t res);
        int dx;
        int dy;
        int ax;
        int ay;
        int span;
        int period;
        produced = 1'b0;
        res = NO_PIXEL;
        if (it.op == sdda_pkg::OP_START)
        begin
            dx = int'(it.xe) - int'(it.xs);
            dy = int'(it.ye) - int'(it.ys);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            span = (ax > ay) ? ax : ay;
            line_style_q = it.st;
            draw_phase = 0;
            steps_to_go = span;
            pos_x = {2'b00, it.xs, 1'b1, {(FRAC-1){1'b0}}};
            pos_y = {2'b00, it.ys, 1'b1, {(FRAC-1){1'b0}}};
            inc_x = (span == 0) ? '0 : slope_of(dx, span);
            inc_y = (span == 0) ? '0 : slope_of(dy, span);
        end
        else if (steps_to_go == 0)
        begin
            produced = 1'b1;
            res = IDLE_PIXEL;
        end
        else
        begin
            produced = 1'b1;
            res.px = pos_x[FRAC+COORD-1:FRAC];
            res.py = pos_y[FRAC+COORD-1:FRAC];
            case (line_style_q)
                sdda_pkg::STYLE_DOT:      res.plot = (draw_phase == 0);
                sdda_pkg::STYLE_DASH:     res.plot = (draw_phase <= DASH_LEN);
                sdda_pkg::STYLE_DASH_DOT: res.plot = (draw_phase <= DASH_LEN)
                                                     || (draw_phase % DOT_SPACING == 0);
                default:                  res.plot = 1'b1;
            endcase
            res.last = (steps_to_go == 1);
            pos_x = pos_x + inc_x;
            pos_y = pos_y + inc_y;
            steps_to_go--;
            period = (line_style_q == sdda_pkg::STYLE_DOT) ? DOT_CYCLE : DASH_CYCLE;
            draw_phase = (draw_phase + 1 >= period) ? 0 : draw_phase + 1;
        end
    endtask

    // Results are compared before the item accepted on the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_pixel = {pixel_x, pixel_y, plot, last, idle};
                if (expected_pixels.size() == 0)
                begin
                    note_mismatch("arrived with nothing expected", int'(seen_pixel.px), 0);
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (seen_pixel.px !== want_pixel.px)
                        note_mismatch("pixel_x", int'(seen_pixel.px), int'(want_pixel.px));
                    if (seen_pixel.py !== want_pixel.py)
                        note_mismatch("pixel_y", int'(seen_pixel.py), int'(want_pixel.py));
                    if (seen_pixel.plot !== want_pixel.plot)
                        note_mismatch("plot", int'(seen_pixel.plot), int'(want_pixel.plot));
                    if (seen_pixel.last !== want_pixel.last)
                        note_mismatch("last", int'(seen_pixel.last), int'(want_pixel.last));
                    if (seen_pixel.idle !== want_pixel.idle)
                        note_mismatch("idle", int'(seen_pixel.idle), int'(want_pixel.idle));
                end
                pixels_checked++;
                idle_seen += int'(seen_pixel.idle);
                last_seen += int'(seen_pixel.last);
                plotted += int'(seen_pixel.plot);
            end
            if (in_valid && !in_stall)
            begin
                rasterize_item({operation, x_start, y_start, x_end, y_end, style},
                               has_pixel, want_pixel);
                if (operation == sdda_pkg::OP_START)
                begin
                    lines_started++;
                end
                if (has_pixel)
                begin
                    expected_pixels.push_back(pin_valid ? pin_result : want_pixel);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99, 0) < receiver_stall_pct);
    end

    initial
    begin
        while (cycle_count < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input line_item_t it, input logic pinned, input pixel_result_t pin);
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= it.op;
        x_start <= it.xs;
        y_start <= it.ys;
        x_end <= it.xe;
        y_end <= it.ye;
        style <= it.st;
        pin_valid <= pinned;
        pin_result <= pin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // in_valid drops and the clock advances before the queue is checked, so the last accepted item is already queued.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [COORD-1:0] nearby(input logic [COORD-1:0] c);
        int lo;
        int hi;
        lo = (int'(c) > NEAR_SPAN) ? int'(c) - NEAR_SPAN : 0;
        hi = (int'(c) + NEAR_SPAN > int'(COORD_MAX)) ? int'(COORD_MAX) : int'(c) + NEAR_SPAN;
        return COORD'($urandom_range(hi, lo));
    endfunction

    initial
    begin
        line_item_t it;
        int phase_idx;
        int phase_goal;
        int sent_random;
        int kind;
        int dx;
        int dy;
        int span;
        int steps;
        int k;
        int idle_plan [4];
        int stall_plan [4];

        idle_plan = '{0, 50, 0, 7};
        stall_plan = '{0, 0, 50, 7};
        sent_random = 0;

        // Typed results are the first pixel of a line, single-step lines and idle answers.
        directed_rows = '{
            '{STEP_ITEM, 1'b1, IDLE_PIXEL},
            '{'{sdda_pkg::OP_START, 12'd0, 12'd0, COORD_MAX, COORD_MAX,
                sdda_pkg::STYLE_SOLID}, 1'b0, NO_PIXEL},
            '{'{sdda_pkg::OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                sdda_pkg::STYLE_SOLID}, 1'b1, '{12'd0, 12'd0, 1'b1, 1'b0, 1'b0}},
            '{'{sdda_pkg::OP_STEP, 12'hABC, 12'h543, 12'h0F0, 12'hF0F,
                sdda_pkg::STYLE_DASH_DOT}, 1'b0, NO_PIXEL},
            '{'{sdda_pkg::OP_START, COORD_MAX, COORD_MAX, 12'd0, 12'd0,
                sdda_pkg::STYLE_DOT}, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, '{COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0}},
            '{STEP_ITEM, 1'b0, NO_PIXEL},
            '{'{sdda_pkg::OP_START, 12'd10, 12'd10, 12'd10, 12'd10,
                sdda_pkg::STYLE_DASH}, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, IDLE_PIXEL},
            '{'{sdda_pkg::OP_START, 12'd5, 12'd5, 12'd7, 12'd4,
                sdda_pkg::STYLE_DASH}, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, '{12'd5, 12'd5, 1'b1, 1'b0, 1'b0}},
            '{STEP_ITEM, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, IDLE_PIXEL},
            '{'{sdda_pkg::OP_START, 12'd0, COORD_MAX, COORD_MAX, 12'd0,
                sdda_pkg::STYLE_DASH_DOT}, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, '{12'd0, COORD_MAX, 1'b1, 1'b0, 1'b0}},
            '{'{sdda_pkg::OP_START, 12'd2000, 12'd1, 12'd1, 12'd2000,
                sdda_pkg::STYLE_DOT}, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, '{12'd2000, 12'd1, 1'b1, 1'b0, 1'b0}},
            '{STEP_ITEM, 1'b0, NO_PIXEL},
            '{'{sdda_pkg::OP_START, COORD_MAX, 12'd0, 12'd4094, 12'd0,
                sdda_pkg::STYLE_DOT}, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, '{COORD_MAX, 12'd0, 1'b1, 1'b1, 1'b0}},
            '{STEP_ITEM, 1'b1, IDLE_PIXEL},
            '{'{sdda_pkg::OP_START, 12'd0, COORD_MAX, 12'd3, 12'd0,
                sdda_pkg::STYLE_SOLID}, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b1, '{12'd0, COORD_MAX, 1'b1, 1'b0, 1'b0}},
            '{STEP_ITEM, 1'b0, NO_PIXEL},
            '{STEP_ITEM, 1'b0, NO_PIXEL}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            send_item(directed_rows[k].item, directed_rows[k].pinned, directed_rows[k].res);
        end
        wait_until_drained();

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            sender_idle_pct = idle_plan[phase_idx];
            receiver_stall_pct = stall_plan[phase_idx];
            phase_goal = sent_random + RANDOM_ITEMS / 4;
            while (sent_random < phase_goal)
            begin
                kind = $urandom_range(99, 0);
                it.op = sdda_pkg::OP_START;
                it.st = 2'($urandom);
                it.xs = COORD'($urandom);
                it.ys = COORD'($urandom);
                if (kind < 65)
                begin
                    it.xe = nearby(it.xs);
                    it.ye = nearby(it.ys);
                end
                else if (kind < 80)
                begin
                    it.xe = COORD'($urandom);
                    it.ye = COORD'($urandom);
                end
                else if (kind < 90)
                begin
                    it.xs = {COORD{1'($urandom)}};
                    it.ys = {COORD{1'($urandom)}};
                    it.xe = {COORD{1'($urandom)}};
                    it.ye = {COORD{1'($urandom)}};
                end
                else
                begin
                    it.xe = it.xs;
                    it.ye = it.ys;
                end
                dx = int'(it.xe) - int'(it.xs);
                dy = int'(it.ye) - int'(it.ys);
                dx = (dx < 0) ? -dx : dx;
                dy = (dy < 0) ? -dy : dy;
                span = (dx > dy) ? dx : dy;
                // Short lines usually run to the end and up to two steps past it;
                // the rest get up to 60 steps, which may stop them short of the end.
                if (span <= 200 && $urandom_range(4, 0) != 0)
                    steps = span + $urandom_range(2, 0);
                else
                    steps = $urandom_range(60, 0);
                send_item(it, 1'b0, NO_PIXEL);
                sent_random++;
                for (k = 0; k < steps; k++)
                begin
                    it = line_item_t'(ITEM_BITS'({$urandom, $urandom}));
                    it.op = sdda_pkg::OP_STEP;
                    send_item(it, 1'b0, NO_PIXEL);
                    sent_random++;
                end
            end
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            note_mismatch("results never arrived", 0, expected_pixels.size());
        end

        $display("Drove %0d lines and checked %0d pixels: %0d idle answers, %0d line ends,",
                 lines_started, pixels_checked, idle_seen, last_seen);
        $display("%0d plotted, across four sender and receiver pacing mixes; %0d mismatches.",
                 plotted, mismatches);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
src/sdda_pkg.sv
src/sdda_ctrl.sv
src/sdda_datapath.sv
src/styled_dda_line_rasterizer.sv
bench/tb_top.sv
